/* rtl/bbsd_pkg.sv */
package bbsd_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 14;

  // decoder phase, one per byte role inside a block; PH_BITMAP covers all bitmap bytes
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_COUNT     = 3'd1,
    PH_X1        = 3'd2,
    PH_Y1        = 3'd3,
    PH_EXT_SHORT = 3'd4,
    PH_EXT_X     = 3'd5,
    PH_EXT_Y     = 3'd6,
    PH_BITMAP    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STATIC = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_BITMAP = 2'd2
  } kind_t;

  // header byte flag positions
  localparam int FlagNew    = 0;
  localparam int FlagFlip   = 1;
  localparam int FlagShort  = 2;
  localparam int FlagStatic = 3;

  typedef struct packed {
    kind_t              kind;
    logic               new_frame;
    logic               flipped;
    logic [ByteW-1:0]   left_x;
    logic [ByteW-1:0]   top_y;
    logic [ByteW-1:0]   extent_x;
    logic [ByteW-1:0]   extent_y;
    logic [ByteW-1:0]   repeat_count;
    logic [ByteW-1:0]   bitmap_byte;
    logic               last_byte;
  } rec_t;

  typedef struct packed {
    logic emit;
    rec_t rec;
  } core_out_t;

endpackage

/* rtl/bitmap_block_stream_decoder.sv */
// Decodes a byte stream of compressed video blocks into records. A header
// byte (bit 0 new frame, bit 1 flipped, bit 2 short extent, bit 3 static,
// bits 7:4 ignored) is followed either by a repeat count byte, which gives a
// static record, or by x1, y1 and an extent (one packed nibble byte when the
// short flag is set, else two bytes), which gives a header record; then the
// ((x2+1)*(y2+1)+7)/8 bitmap bytes of the block come out one record each,
// the final one with last_byte set. The block takes one stream beat every
// clock while stream_stall is low: a beat is held in the input register, the
// decoder updates its state and forms the record from it combinationally,
// and the record is registered in the output register. Beats that close no
// record (header, x1, y1, first extent byte) produce no output beat.
// Both channels use valid/stall; stream_stall rises only when a record waits
// in the output register under record_stall and a beat is held in the input
// register behind it.
// Fields that do not belong to a record's kind read as zero.
module bitmap_block_stream_decoder (
  input  logic        clk,
  input  logic        rst,

  // input stream
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,

  // record output
  output logic        record_valid,
  input  logic        record_stall,
  output logic [1:0]  record_kind,
  output logic        new_frame,
  output logic        flipped,
  output logic [7:0]  left_x,
  output logic [7:0]  top_y,
  output logic [7:0]  extent_x,
  output logic [7:0]  extent_y,
  output logic [7:0]  repeat_count,
  output logic [7:0]  bitmap_byte,
  output logic        last_byte
);

  // input register
  logic                          in_vld;
  logic [bbsd_pkg::ByteW-1:0]    in_byte;

  // output register
  logic                          out_vld;
  bbsd_pkg::rec_t                out_rec;

  bbsd_pkg::core_out_t           core_res;
  logic                          advance;
  logic                          accept;

  // the held beat moves on whenever the output register is free or draining
  assign advance      = in_vld && (!out_vld || !record_stall);
  assign stream_stall = in_vld && !advance;
  assign accept       = stream_valid && !stream_stall;

  bbsd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= stream_byte;
    end
  end

  // record register, refilled as soon as the previous record is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= core_res.emit;
    end else if (!record_stall) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.emit) begin
      out_rec <= core_res.rec;
    end
  end

  assign record_valid = out_vld;
  assign record_kind  = out_rec.kind;
  assign new_frame    = out_rec.new_frame;
  assign flipped      = out_rec.flipped;
  assign left_x       = out_rec.left_x;
  assign top_y        = out_rec.top_y;
  assign extent_x     = out_rec.extent_x;
  assign extent_y     = out_rec.extent_y;
  assign repeat_count = out_rec.repeat_count;
  assign bitmap_byte  = out_rec.bitmap_byte;
  assign last_byte    = out_rec.last_byte;

endmodule

/* rtl/bbsd_core.sv */
module bbsd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [bbsd_pkg::ByteW-1:0] byte_in,
  output bbsd_pkg::core_out_t       result
);

  bbsd_pkg::phase_t                phase, phase_next;
  logic [2:0]                      header_flags, header_flags_next;
  logic [bbsd_pkg::ByteW-1:0]      origin_x, origin_x_next;
  logic [bbsd_pkg::ByteW-1:0]      origin_y, origin_y_next;
  logic [bbsd_pkg::ByteW-1:0]      size_x, size_x_next;
  logic [bbsd_pkg::ByteW-1:0]      size_y, size_y_next;
  logic [bbsd_pkg::CountW-1:0]     bytes_left, bytes_left_next;

  logic [bbsd_pkg::ByteW-1:0]      ext_x, ext_y;
  logic [17:0]                     area;
  logic [17:0]                     area_round;
  logic [bbsd_pkg::CountW-1:0]     block_bytes;
  logic [bbsd_pkg::CountW-1:0]     bl_dec;
  logic                            bl_last;

  // extent as seen on the byte that closes the header
  always_comb begin
    if (phase == bbsd_pkg::PH_EXT_SHORT) begin
      ext_x = {4'd0, byte_in[3:0]};
      ext_y = {4'd0, byte_in[7:4]};
    end else begin
      ext_x = size_x;
      ext_y = byte_in;
    end
  end

  // bitmap length in bytes, rounded up
  assign area        = ({10'd0, ext_x} + 18'd1) * ({10'd0, ext_y} + 18'd1);
  assign area_round  = area + 18'd7;
  assign block_bytes = area_round[16:3];

  assign bl_dec  = (bytes_left != '0) ? bytes_left - 14'd1 : bytes_left;
  assign bl_last = (bl_dec == '0);

  always_comb begin
    phase_next        = phase;
    header_flags_next = header_flags;
    origin_x_next     = origin_x;
    origin_y_next     = origin_y;
    size_x_next       = size_x;
    size_y_next       = size_y;
    bytes_left_next   = bytes_left;
    unique case (phase)
      bbsd_pkg::PH_HEADER: begin
        header_flags_next = byte_in[2:0];
        phase_next = byte_in[bbsd_pkg::FlagStatic] ? bbsd_pkg::PH_COUNT : bbsd_pkg::PH_X1;
      end
      bbsd_pkg::PH_COUNT: begin
        phase_next = bbsd_pkg::PH_HEADER;
      end
      bbsd_pkg::PH_X1: begin
        origin_x_next = byte_in;
        phase_next    = bbsd_pkg::PH_Y1;
      end
      bbsd_pkg::PH_Y1: begin
        origin_y_next = byte_in;
        phase_next = header_flags[bbsd_pkg::FlagShort] ? bbsd_pkg::PH_EXT_SHORT
                                                       : bbsd_pkg::PH_EXT_X;
      end
      bbsd_pkg::PH_EXT_SHORT, bbsd_pkg::PH_EXT_Y: begin
        size_x_next     = ext_x;
        size_y_next     = ext_y;
        bytes_left_next = block_bytes;
        phase_next      = bbsd_pkg::PH_BITMAP;
      end
      bbsd_pkg::PH_EXT_X: begin
        size_x_next = byte_in;
        phase_next  = bbsd_pkg::PH_EXT_Y;
      end
      bbsd_pkg::PH_BITMAP: begin
        bytes_left_next = bl_dec;
        if (bl_last) begin
          phase_next = bbsd_pkg::PH_HEADER;
        end
      end
    endcase
  end

  always_comb begin
    result = '0;
    unique case (phase)
      bbsd_pkg::PH_COUNT: begin
        result.emit             = 1'b1;
        result.rec.kind         = bbsd_pkg::KIND_STATIC;
        result.rec.new_frame    = header_flags[bbsd_pkg::FlagNew];
        result.rec.flipped      = header_flags[bbsd_pkg::FlagFlip];
        result.rec.repeat_count = byte_in;
      end
      bbsd_pkg::PH_EXT_SHORT, bbsd_pkg::PH_EXT_Y: begin
        result.emit          = 1'b1;
        result.rec.kind      = bbsd_pkg::KIND_HEADER;
        result.rec.new_frame = header_flags[bbsd_pkg::FlagNew];
        result.rec.flipped   = header_flags[bbsd_pkg::FlagFlip];
        result.rec.left_x    = origin_x;
        result.rec.top_y     = origin_y;
        result.rec.extent_x  = ext_x;
        result.rec.extent_y  = ext_y;
      end
      bbsd_pkg::PH_BITMAP: begin
        result.emit            = 1'b1;
        result.rec.kind        = bbsd_pkg::KIND_BITMAP;
        result.rec.bitmap_byte = byte_in;
        result.rec.last_byte   = bl_last;
      end
      bbsd_pkg::PH_HEADER, bbsd_pkg::PH_X1, bbsd_pkg::PH_Y1, bbsd_pkg::PH_EXT_X: begin
        result.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bbsd_pkg::PH_HEADER;
      header_flags <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      size_x       <= '0;
      size_y       <= '0;
      bytes_left   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      header_flags <= header_flags_next;
      origin_x     <= origin_x_next;
      origin_y     <= origin_y_next;
      size_x       <= size_x_next;
      size_y       <= size_y_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule
